FILE: rtl/core/actp_pkg.sv
// ----------------------------------------------------------------------------
// actp_pkg
// Shared types, codes and helper functions for the ANSI colour text placer.
// ----------------------------------------------------------------------------
package actp_pkg;

    localparam int BYTE_W     = 8;
    localparam int ROW_LIMIT  = 4096;
    localparam int ROW_W      = $clog2(ROW_LIMIT);
    localparam int ROW_OUT_W  = 12;
    localparam int COL_W      = 8;
    localparam int COLOR_W    = 3;
    localparam int ARG_W      = 8;
    localparam int ARG_SUM_W  = 12;

    localparam logic [COL_W-1:0] LINE_WIDTH_RESET = 8'd200;

    // Parser modes
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_SGR  = 2'd2;
    localparam logic [1:0] MODE_SKIP = 2'd3;

    // Byte codes
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_FINAL  = 8'h40;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SGR_M  = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;

    // SGR argument codes
    localparam logic [ARG_W-1:0] SGR_RESET     = 8'd0;
    localparam logic [ARG_W-1:0] SGR_FG_FIRST  = 8'd31;
    localparam logic [ARG_W-1:0] SGR_FG_LAST   = 8'd36;
    localparam logic [ARG_W-1:0] SGR_FG_OFFSET = 8'd30;
    localparam logic [ARG_W-1:0] ARG_MAX       = 8'd255;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 3'd0;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              restart;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]    glyph;
        logic [ROW_OUT_W-1:0] cell_row;
        logic [COL_W-1:0]     cell_column;
        logic [COLOR_W-1:0]   glyph_color;
    } t_result;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ARG_W-1:0]   arg_value;
        logic               arg_seen;
        logic [COLOR_W-1:0] pending_color;
        logic [COLOR_W-1:0] text_color;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode:          MODE_TEXT,
        arg_value:     '0,
        arg_seen:      1'b0,
        pending_color: COLOR_WHITE,
        text_color:    COLOR_WHITE,
        row:           '0,
        column:        '0
    };

    function automatic logic [ROW_W-1:0] row_advance(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] res;
        if (row == ROW_W'(ROW_LIMIT - 1)) begin
            res = '0;
        end else begin
            res = row + 1'b1;
        end
        return res;
    endfunction

    // Close an SGR argument: 0 selects white, 31..36 select a colour.
    function automatic logic [COLOR_W-1:0] close_arg(input logic [ARG_W-1:0]   value,
                                                     input logic               seen,
                                                     input logic [COLOR_W-1:0] pending);
        logic [COLOR_W-1:0] res;
        res = pending;
        if (seen) begin
            if (value == SGR_RESET) begin
                res = COLOR_WHITE;
            end else if (value >= SGR_FG_FIRST && value <= SGR_FG_LAST) begin
                res = COLOR_W'(value - SGR_FG_OFFSET);
            end
        end
        return res;
    endfunction

    // Append one decimal digit, saturating at the argument maximum.
    function automatic logic [ARG_W-1:0] arg_append(input logic [ARG_W-1:0]  value,
                                                    input logic [BYTE_W-1:0] digit);
        logic [ARG_SUM_W-1:0] sum;
        sum = (ARG_SUM_W'({value, 3'b000}) + ARG_SUM_W'({value, 1'b0}))
              + ARG_SUM_W'(digit - CH_ZERO);
        return (sum > ARG_SUM_W'(ARG_MAX)) ? ARG_MAX : sum[ARG_W-1:0];
    endfunction

endpackage

FILE: rtl/core/actp_if.sv
// ----------------------------------------------------------------------------
// actp_if
// Valid/ready channel interfaces: byte stream in, placed cells out, config.
// ----------------------------------------------------------------------------
interface actp_stream_if
    import actp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              restart;

    modport source (output valid, output stream_byte, output restart, input ready);
    modport sink   (input valid, input stream_byte, input restart, output ready);
endinterface

interface actp_cell_if
    import actp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    glyph;
    logic [ROW_OUT_W-1:0] cell_row;
    logic [COL_W-1:0]     cell_column;
    logic [COLOR_W-1:0]   glyph_color;

    modport source (output valid, output glyph, output cell_row, output cell_column,
                    output glyph_color, input ready);
    modport sink   (input valid, input glyph, input cell_row, input cell_column,
                    input glyph_color, output ready);
endinterface

interface actp_cfg_if
    import actp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] line_width;

    modport source (output valid, output line_width, input ready);
    modport sink   (input valid, input line_width, output ready);
endinterface

FILE: rtl/core/ansi_color_text_placer.sv
// ----------------------------------------------------------------------------
// ansi_color_text_placer
// Place terminal output bytes in character cells with ANSI SGR colours.
// ----------------------------------------------------------------------------
// The block takes one byte per clock on i_stream as long as o_cell does
// not stall: every byte is captured in the input register and is then
// worked through the parser and cell placer combinationally, whose state
// register closes the only loop; a placed glyph goes into the result
// register and is offered on o_cell from there. Bytes that place nothing
// (CR, LF, NUL and the bytes of escape sequences) produce no transfer on
// o_cell. The result register parts the two sides, so a new byte is taken
// while a finished cell still waits; when o_cell stalls, i_stream backs up
// after one byte. The user must write line_width on i_cfg only while the
// block is idle; the block itself does not enforce it. line_width resets
// to 200. Setting restart with a byte clears row, column, colours and the
// parser before that byte is handled.
module ansi_color_text_placer
    import actp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    actp_stream_if.sink   i_stream,
    actp_cfg_if.sink      i_cfg,
    actp_cell_if.source   o_cell
);

    logic             w_in_valid;
    t_in_item         w_in_item;
    logic             w_advance;
    t_state           w_next_state;
    logic             w_emit;
    t_result          w_result;

    t_state           r_state;
    logic [COL_W-1:0] r_line_width;
    logic             r_out_valid;
    t_result          r_out;

    // Advance the held byte once the result register is free or draining.
    assign w_advance = w_in_valid && (!r_out_valid || o_cell.ready);

    actp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stream  (i_stream),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    actp_step u_step (
        .i_state      (r_state),
        .i_item       (w_in_item),
        .i_line_width (r_line_width),
        .o_state      (w_next_state),
        .o_emit       (w_emit),
        .o_result     (w_result)
    );

    // Configuration: always ready, one transfer writes the line width.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_line_width <= i_cfg.line_width;
        end
    end

    // Parser and cursor state: update on every advanced byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_advance) begin
            r_state <= w_next_state;
        end
    end

    // Result register: load a placed cell, drop valid after the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end else if (o_cell.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_cell.valid       = r_out_valid;
    assign o_cell.glyph       = r_out.glyph;
    assign o_cell.cell_row    = r_out.cell_row;
    assign o_cell.cell_column = r_out.cell_column;
    assign o_cell.glyph_color = r_out.glyph_color;

endmodule

FILE: rtl/core/actp_in_reg.sv
// ----------------------------------------------------------------------------
// actp_in_reg
// Input register stage: capture one stream byte per transfer.
// ----------------------------------------------------------------------------
module actp_in_reg
    import actp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    actp_stream_if.sink   i_stream,
    input  logic          i_advance,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_take;

    assign i_stream.ready = !r_valid || i_advance;
    assign w_take         = i_stream.valid && i_stream.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.stream_byte <= i_stream.stream_byte;
            r_item.restart     <= i_stream.restart;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/core/actp_step.sv
// ----------------------------------------------------------------------------
// actp_step
// Next-state logic for one byte: escape parsing, colour and cell placement.
// ----------------------------------------------------------------------------
module actp_step
    import actp_pkg::*;
(
    input  t_state            i_state,
    input  t_in_item          i_item,
    input  logic [COL_W-1:0]  i_line_width,
    output t_state            o_state,
    output logic              o_emit,
    output t_result           o_result
);

    t_state            w_cur;
    t_state            w_nxt;
    logic              w_text;
    logic              w_emit;
    logic [BYTE_W-1:0] w_b;

    assign w_b   = i_item.stream_byte;
    assign w_cur = i_item.restart ? STATE_RESET : i_state;

    always_comb begin
        w_nxt  = w_cur;
        w_text = 1'b0;
        w_emit = 1'b0;

        case (w_cur.mode)
            MODE_ESC: begin
                if (w_b == CH_LBRACK) begin
                    w_nxt.mode          = MODE_SGR;
                    w_nxt.arg_value     = '0;
                    w_nxt.arg_seen      = 1'b0;
                    w_nxt.pending_color = w_cur.text_color;
                end else begin
                    w_nxt.mode = MODE_TEXT;
                    w_text     = 1'b1;
                end
            end
            MODE_SGR, MODE_SKIP: begin
                if (w_b < CH_SPACE || w_b > CH_TILDE) begin
                    // abort the sequence, treat the byte as text
                    w_nxt.mode      = MODE_TEXT;
                    w_nxt.arg_value = '0;
                    w_nxt.arg_seen  = 1'b0;
                    w_text          = 1'b1;
                end else if (w_b >= CH_FINAL) begin
                    if (w_cur.mode == MODE_SGR && w_b == CH_SGR_M) begin
                        w_nxt.text_color = close_arg(w_cur.arg_value, w_cur.arg_seen,
                                                     w_cur.pending_color);
                        w_nxt.pending_color = w_nxt.text_color;
                    end
                    w_nxt.mode      = MODE_TEXT;
                    w_nxt.arg_value = '0;
                    w_nxt.arg_seen  = 1'b0;
                end else if (w_cur.mode == MODE_SGR) begin
                    if (w_b inside {[CH_ZERO:CH_NINE]}) begin
                        w_nxt.arg_value = arg_append(w_cur.arg_value, w_b);
                        w_nxt.arg_seen  = 1'b1;
                    end else if (w_b == CH_SEMI) begin
                        w_nxt.pending_color = close_arg(w_cur.arg_value, w_cur.arg_seen,
                                                        w_cur.pending_color);
                        w_nxt.arg_value     = '0;
                        w_nxt.arg_seen      = 1'b0;
                    end else begin
                        w_nxt.mode = MODE_SKIP;
                    end
                end
            end
            default: begin
                w_text = 1'b1;
            end
        endcase

        o_result.glyph       = w_b;
        o_result.cell_row    = ROW_OUT_W'(w_nxt.row);
        o_result.cell_column = w_nxt.column;
        o_result.glyph_color = w_nxt.text_color;

        if (w_text) begin
            if (w_b == CH_CR) begin
                // ignore carriage return
            end else if (w_b == CH_LF || w_b == CH_NUL) begin
                w_nxt.row    = row_advance(w_nxt.row);
                w_nxt.column = '0;
            end else if (w_b == CH_ESC) begin
                w_nxt.mode = MODE_ESC;
            end else begin
                if (w_nxt.column >= i_line_width) begin
                    w_nxt.row    = row_advance(w_nxt.row);
                    w_nxt.column = '0;
                end
                o_result.cell_row    = ROW_OUT_W'(w_nxt.row);
                o_result.cell_column = w_nxt.column;
                w_emit               = 1'b1;
                w_nxt.column         = w_nxt.column + 1'b1;
            end
        end
    end

    assign o_state = w_nxt;
    assign o_emit  = w_emit;

endmodule

FILE: rtl/core/actp_checker.sv
// ----------------------------------------------------------------------------
// actp_checker
// Port-level checks for the text placer, bound to the top level.
// ----------------------------------------------------------------------------
module actp_checker
    import actp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [BYTE_W-1:0]    i_glyph,
    input logic [ROW_OUT_W-1:0] i_cell_row
);

    // hold a stalled cell
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_glyph) && $stable(i_cell_row))
        else $error("stalled cell changed or vanished");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("cell valid after reset");

    // a fresh cell comes from a byte transfer, through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("cell appeared without a byte transfer");

    a_no_control: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_glyph != CH_CR) && (i_glyph != CH_LF) &&
                        (i_glyph != CH_NUL) && (i_glyph != CH_ESC))
        else $error("control byte placed in a cell");

endmodule

bind ansi_color_text_placer actp_checker u_actp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_stream.valid),
    .i_in_ready  (i_stream.ready),
    .i_out_valid (o_cell.valid),
    .i_out_ready (o_cell.ready),
    .i_glyph     (o_cell.glyph),
    .i_cell_row  (o_cell.cell_row)
);

FILE: bench/ansi_color_text_placer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ansi_color_text_placer_tb
// Self-checking bench for the ANSI colour text placer: drives byte streams
// (plain text, SGR colour sequences, other and broken CSI sequences, line
// controls and restarts) under several line widths, predicts every placed
// cell and compares each cell transfer against the prediction.
// ----------------------------------------------------------------------------
module ansi_color_text_placer_tb
    import actp_pkg::*;
;

    localparam int  WATCHDOG_LIMIT = 4000;  // cycles without any transfer
    localparam int  LONG_HOLD      = 400;   // long receiver hold-off
    localparam int  PIPE_SETTLE    = 6;     // bytes that place nothing may still be in flight
    localparam logic [7:0] CH_QMARK = 8'h3F;  // private parameter byte

    // ------------------------------------------------------------------------
    // Cell placement predictor and expected-cell store
    // ------------------------------------------------------------------------
    class cell_scoreboard;
        logic [1:0]         mode;
        logic [ARG_W-1:0]   arg_value;
        logic               arg_seen;
        logic [COLOR_W-1:0] pending_color;
        logic [COLOR_W-1:0] text_color;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [COL_W-1:0]   line_width;
        t_result            expected_cells[$];
        int                 errors;

        function new();
            line_width = LINE_WIDTH_RESET;
            errors     = 0;
            home_cursor();
        endfunction

        function void home_cursor();
            mode          = MODE_TEXT;
            arg_value     = '0;
            arg_seen      = 1'b0;
            pending_color = COLOR_WHITE;
            text_color    = COLOR_WHITE;
            row           = '0;
            column        = '0;
        endfunction

        function void set_line_width(input logic [COL_W-1:0] width);
            line_width = width;
        endfunction

        function void line_break();
            row    = row_advance(row);  // wraps at the row limit
            column = '0;
        endfunction

        function void drop_argument();
            arg_value = '0;
            arg_seen  = 1'b0;
        endfunction

        // 0 selects white, 31..36 select a colour, anything else is ignored
        function void commit_sgr_argument();
            if (arg_seen) begin
                if (arg_value == SGR_RESET) begin
                    pending_color = COLOR_WHITE;
                end else if (arg_value >= SGR_FG_FIRST && arg_value <= SGR_FG_LAST) begin
                    pending_color = COLOR_W'(arg_value - SGR_FG_OFFSET);
                end
            end
            drop_argument();
        endfunction

        function void place_glyph(input logic [7:0] b);
            t_result placed;
            if (b == CH_CR) begin
                return;
            end
            if (b == CH_LF || b == CH_NUL) begin
                line_break();
                return;
            end
            if (b == CH_ESC) begin
                mode = MODE_ESC;
                return;
            end
            if (column >= line_width) begin
                line_break();
            end
            placed.glyph       = b;
            placed.cell_row    = ROW_OUT_W'(row);
            placed.cell_column = column;
            placed.glyph_color = text_color;
            expected_cells.push_back(placed);
            column = column + 1'b1;
        endfunction

        // Note one accepted input transfer.
        function void note_byte(input logic [7:0] b, input logic restart);
            int acc;
            if (restart) begin
                home_cursor();
            end
            case (mode)
                MODE_ESC: begin
                    if (b == CH_LBRACK) begin
                        mode          = MODE_SGR;
                        pending_color = text_color;
                        drop_argument();
                    end else begin
                        mode = MODE_TEXT;
                        place_glyph(b);
                    end
                end
                MODE_SGR, MODE_SKIP: begin
                    if (b < CH_SPACE || b > CH_TILDE) begin
                        mode = MODE_TEXT;
                        drop_argument();
                        place_glyph(b);
                    end else if (b >= CH_FINAL) begin
                        if (mode == MODE_SGR && b == CH_SGR_M) begin
                            commit_sgr_argument();
                            text_color = pending_color;
                        end
                        mode = MODE_TEXT;
                        drop_argument();
                    end else if (mode == MODE_SGR) begin
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            acc = int'(arg_value) * 10 + int'(b) - int'(CH_ZERO);
                            arg_value = (acc > int'(ARG_MAX)) ? ARG_MAX : ARG_W'(acc);
                            arg_seen  = 1'b1;
                        end else if (b == CH_SEMI) begin
                            commit_sgr_argument();
                        end else begin
                            mode = MODE_SKIP;
                        end
                    end
                end
                default: place_glyph(b);
            endcase
        endfunction

        function void report(input string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void compare_field(input string field_name, input logic [11:0] want,
                                    input logic [11:0] got);
            if (got !== want) begin
                report($sformatf("%s mismatch: expected %0h, actual %0h",
                                 field_name, want, got));
            end
        endfunction

        // Check one accepted cell transfer against the oldest expectation.
        function void check_cell(input t_result got);
            t_result want;
            if (expected_cells.size() == 0) begin
                report($sformatf({"unexpected cell: expected none, ",
                                  "actual glyph %0h row %0h col %0h colour %0h"},
                                 got.glyph, got.cell_row, got.cell_column, got.glyph_color));
                return;
            end
            want = expected_cells.pop_front();
            compare_field("glyph", 12'(want.glyph), 12'(got.glyph));
            compare_field("cell_row", want.cell_row, got.cell_row);
            compare_field("cell_column", 12'(want.cell_column), 12'(got.cell_column));
            compare_field("glyph_color", 12'(want.glyph_color), 12'(got.glyph_color));
        endfunction

        function int pending_count();
            return expected_cells.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    actp_stream_if stream_if ();
    actp_cfg_if    cfg_if ();
    actp_cell_if   cell_if ();

    ansi_color_text_placer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stream (stream_if),
        .i_cfg    (cfg_if),
        .o_cell   (cell_if)
    );

    cell_scoreboard sb = new();

    int idle_pct;        // chance per byte of a sender gap
    int stall_pct;       // chance per cycle of a receiver stall
    int restart_odds;    // 1 in this many bytes carries restart; 0 disables
    bit restart_next;
    bit long_hold_req;
    int bytes_sent;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive every input to a known value from time zero.
    initial begin
        i_rst_n               <= 1'b0;
        stream_if.valid       <= 1'b0;
        stream_if.stream_byte <= '0;
        stream_if.restart     <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.line_width     <= LINE_WIDTH_RESET;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request so the
    // block fills up and backs up its input.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        cell_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                cell_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                gap = $urandom_range(1, 14);
                cell_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                cell_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Transfer monitor and watchdog. Sample at the edge, before any of this
    // edge's nonblocking updates land.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (cell_if.valid && cell_if.ready) begin
                got.glyph       = cell_if.glyph;
                got.cell_row    = cell_if.cell_row;
                got.cell_column = cell_if.cell_column;
                got.glyph_color = cell_if.glyph_color;
                sb.check_cell(got);
                moved = 1'b1;
            end
            if (stream_if.valid && stream_if.ready) begin
                sb.note_byte(stream_if.stream_byte, stream_if.restart);
                moved = 1'b1;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                sb.set_line_width(cfg_if.line_width);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stream driving
    // ------------------------------------------------------------------------

    // Offer one byte and hold it until the transfer. Valid stays high into
    // the next byte unless a gap is taken.
    task automatic send_byte(input logic [7:0] value);
        int   gap;
        logic rs;
        rs = restart_next || (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
        restart_next = 1'b0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 14);
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= value;
        stream_if.restart     <= rs;
        @(posedge i_clk);
        while (!stream_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic stop_stream();
        stream_if.valid <= 1'b0;
    endtask

    // Wait until every expected cell has arrived, then let bytes that place
    // nothing work their way out of the pipeline.
    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // Write line_width; only ever called with the block idle.
    task automatic write_line_width(input logic [COL_W-1:0] width);
        stop_stream();
        wait_drained();
        cfg_if.valid      <= 1'b1;
        cfg_if.line_width <= width;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_number(input int v);
        string digits;
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) begin
            send_byte(8'(digits[i]));
        end
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(int'(CH_SPACE), int'(CH_TILDE)));
    endfunction

    // One random chunk of terminal output: mostly well-formed text and SGR
    // sequences, with other CSI, broken sequences and raw bytes mixed in.
    task automatic send_chunk();
        int kind;
        int n;
        int nargs;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 38) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : printable());
            end
        end else if (kind < 41) begin
            // long run without a line break, to reach the wrap at wide lines
            n = $urandom_range(100, 300);
            repeat (n) send_byte(printable());
        end else if (kind < 51) begin
            pick = $urandom_range(0, 2);
            send_byte(pick == 0 ? CH_CR : (pick == 1 ? CH_LF : CH_NUL));
        end else if (kind < 78) begin
            // well-formed SGR: ESC [ args m
            send_byte(CH_ESC);
            send_byte(CH_LBRACK);
            nargs = $urandom_range(0, 3);
            for (int i = 0; i < nargs; i++) begin
                if (i != 0) send_byte(CH_SEMI);
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    // empty argument
                end else if (pick < 4) begin
                    send_number(0);
                end else if (pick < 8) begin
                    send_number($urandom_range(int'(SGR_FG_FIRST), int'(SGR_FG_LAST)));
                end else begin
                    send_number($urandom_range(0, 999));
                end
            end
            send_byte(CH_SGR_M);
        end else if (kind < 89) begin
            // other CSI: parameter or intermediate bytes, any final byte
            send_byte(CH_ESC);
            send_byte(CH_LBRACK);
            n = $urandom_range(0, 3);
            repeat (n) send_byte(8'($urandom_range(int'(CH_ZERO), int'(CH_QMARK))));
            if ($urandom_range(0, 1) == 1) begin
                send_byte(8'($urandom_range(int'(CH_SPACE), int'(CH_ZERO) - 1)));
            end
            send_byte(8'($urandom_range(int'(CH_FINAL), int'(CH_TILDE))));
        end else begin
            // broken sequences
            send_byte(CH_ESC);
            if ($urandom_range(0, 1) == 0) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(CH_LBRACK);
                send_number($urandom_range(0, 40));
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(8'($urandom_range(0, int'(CH_SPACE) - 1)));
                end else begin
                    send_byte(8'($urandom_range(int'(CH_TILDE) + 1, 255)));
                end
            end
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target) send_chunk();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] opening[$];
        int         leftover;

        idle_pct     = 20;
        stall_pct    = 20;
        restart_odds = 0;
        bytes_sent   = 0;
        quiet_cycles = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening at the reset width: restart, byte extremes, line
        // controls, a dropped escape, a saturated argument with a colour,
        // a private CSI, and a sequence cut short by a line feed.
        opening = '{8'h41, 8'hFF, CH_CR, CH_LF, CH_NUL,
                    CH_ESC, 8'h78,
                    CH_ESC, CH_LBRACK, CH_NINE, CH_NINE, CH_NINE, CH_SEMI,
                    CH_ZERO + 8'd3, CH_ZERO + 8'd4, CH_SGR_M, 8'h42,
                    CH_ESC, CH_LBRACK, CH_QMARK, 8'h68,
                    CH_ESC, CH_LBRACK, CH_ZERO + 8'd3, CH_ZERO + 8'd2, CH_LF, 8'h43};
        restart_next = 1'b1;
        foreach (opening[i]) send_byte(opening[i]);

        // Widest lines; hold the receiver off while bytes keep coming.
        write_line_width(8'd255);
        restart_odds = 150;
        idle_pct     = 15;
        stall_pct    = 25;
        long_hold_req = 1'b1;
        repeat (60) send_byte(printable());
        run_random(300);

        // Narrowest lines, no idling on either side.
        write_line_width(8'd1);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(250);

        // Random narrow width, heavy idling; pause until all cells are out.
        write_line_width(8'($urandom_range(2, 40)));
        idle_pct  = 30;
        stall_pct = 30;
        run_random(150);
        stop_stream();
        wait_drained();
        run_random(150);

        // Dense line breaks at the narrowest width, no restart.
        write_line_width(8'd1);
        restart_odds = 0;
        idle_pct     = 5;
        stall_pct    = 5;
        repeat (400) begin
            if ($urandom_range(0, 9) < 7) begin
                send_byte(($urandom_range(0, 1) == 0) ? CH_LF : CH_NUL);
            end else begin
                send_byte(printable());
            end
        end

        // Last part: wide random width, no idling at all.
        write_line_width(8'($urandom_range(100, 254)));
        restart_odds = 150;
        idle_pct     = 0;
        stall_pct    = 0;
        run_random(350);

        stop_stream();
        wait_drained();
        repeat (20) @(posedge i_clk);

        leftover = sb.pending_count();
        if (leftover != 0) begin
            sb.report($sformatf("%0d expected cells never arrived", leftover));
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/actp_pkg.sv
rtl/core/actp_if.sv
rtl/core/actp_in_reg.sv
rtl/core/actp_step.sv
rtl/core/ansi_color_text_placer.sv
rtl/core/actp_checker.sv
bench/ansi_color_text_placer_tb.sv
